// File: rtl/frwl_pkg.sv
// Package for the fair reader/writer lock arbiter.
// Holds the event and status codes, the controller states and default sizes.
// No dependencies.
package frwl_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_BITS_DEF     = 8;

  typedef enum logic [1:0] {
    ACT_READ_REQ  = 2'd0,
    ACT_WRITE_REQ = 2'd1,
    ACT_READ_REL  = 2'd2,
    ACT_WRITE_REL = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NO_HOLDER = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SERVE,
    ST_SCAN,
    ST_EMIT,
    ST_REPORT
  } state_e;

endpackage

// File: rtl/frwl_req_if.sv
// Event channel of the reader/writer lock arbiter: valid, ready and one event.
// Depends on frwl_pkg.
interface frwl_req_if #(
  parameter int unsigned ID_BITS = frwl_pkg::ID_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  frwl_pkg::action_e    action;
  logic [ID_BITS-1:0]   requester_id;

  modport source (output valid, output action, output requester_id, input ready);
  modport sink   (input valid, input action, input requester_id, output ready);
endinterface

// File: rtl/frwl_rsp_if.sv
// Result channel of the reader/writer lock arbiter: valid, ready and one result.
// Depends on frwl_pkg.
interface frwl_rsp_if #(
  parameter int unsigned QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = frwl_pkg::ID_BITS_DEF
);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RC_W  = ID_BITS + 1;

  logic               valid;
  logic               ready;
  logic               grant_valid;
  logic [ID_BITS-1:0] grant_id;
  logic               grant_write;
  logic               last;
  frwl_pkg::status_e  status;
  logic [CNT_W-1:0]   pending_count;
  logic [RC_W-1:0]    reader_count;
  logic               writer_holds;

  modport source (
    output valid, output grant_valid, output grant_id, output grant_write, output last,
    output status, output pending_count, output reader_count, output writer_holds,
    input ready
  );
  modport sink (
    input valid, input grant_valid, input grant_id, input grant_write, input last,
    input status, input pending_count, input reader_count, input writer_holds,
    output ready
  );
endinterface

// File: rtl/fair_readers_writer_lock_arbiter.sv
// Fair reader/writer lock arbiter. One event is taken at a time; the event port is
// ready only while the block is idle. A refused event (queue full, release with no
// holder) goes through acceptance and one status transaction. Any other event goes
// through acceptance, a serve step and an examination of queue entries from the
// head (the granted entries, plus an entry that stops the batch), then its result
// transactions, which wait while the result side is not ready; grants are first
// counted and then read back through the single read port of the wait-queue memory
// to be reported. An event with no grant ends in one status transaction.
// Depends on frwl_pkg, frwl_req_if and frwl_rsp_if.
module fair_readers_writer_lock_arbiter #(
  parameter int unsigned QUEUE_DEPTH = frwl_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = frwl_pkg::ID_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  frwl_req_if.sink   req_i,
  frwl_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RC_W       = ID_BITS + 1;
  localparam int unsigned ENTRY_W    = ID_BITS + 1;
  localparam int unsigned READER_MAX = 1 << ID_BITS;

  // Ring slot at a given offset from a base slot.
  function automatic logic [IDX_W-1:0] slot_at(logic [IDX_W-1:0] base,
                                               logic [IDX_W-1:0] offset);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] slot_next(logic [IDX_W-1:0] s);
    return (s == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : s + IDX_W'(1);
  endfunction

  // Wait queue: bit ID_BITS marks a write request, the low bits hold the id.
  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  frwl_pkg::state_e  state_q, state_d;
  frwl_pkg::status_e status_q, status_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [RC_W-1:0]   readers_q, readers_d;
  logic              writer_q, writer_d;
  logic [CNT_W-1:0]  ngrant_q, ngrant_d;
  logic [CNT_W-1:0]  emit_idx_q, emit_idx_d;
  logic [IDX_W-1:0]  emit_slot_q, emit_slot_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frwl_pkg::ST_IDLE;
      status_q    <= frwl_pkg::STATUS_OK;
      head_q      <= '0;
      fill_q      <= '0;
      readers_q   <= '0;
      writer_q    <= 1'b0;
      ngrant_q    <= '0;
      emit_idx_q  <= '0;
      emit_slot_q <= '0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      readers_q   <= readers_d;
      writer_q    <= writer_d;
      ngrant_q    <= ngrant_d;
      emit_idx_q  <= emit_idx_d;
      emit_slot_q <= emit_slot_d;
    end
  end

  logic             entry_write;
  logic             take;
  logic [CNT_W-1:0] ngrant_after;
  logic             emit_last;

  assign entry_write = rdata_q[ID_BITS];
  assign emit_last   = ((emit_idx_q + CNT_W'(1)) == ngrant_q);

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    head_d      = head_q;
    fill_d      = fill_q;
    readers_d   = readers_q;
    writer_d    = writer_q;
    ngrant_d    = ngrant_q;
    emit_idx_d  = emit_idx_q;
    emit_slot_d = emit_slot_q;
    wr_en       = 1'b0;
    wr_addr     = slot_at(head_q, fill_q[IDX_W-1:0]);
    wr_data     = {(req_i.action == frwl_pkg::ACT_WRITE_REQ), req_i.requester_id};
    rd_en       = 1'b0;
    rd_addr     = head_q;
    take        = 1'b0;
    ngrant_after = ngrant_q;

    req_i.ready         = 1'b0;
    rsp_o.valid         = 1'b0;
    rsp_o.grant_valid   = 1'b0;
    rsp_o.grant_id      = '0;
    rsp_o.grant_write   = 1'b0;
    rsp_o.last          = 1'b1;
    rsp_o.status        = status_q;
    rsp_o.pending_count = fill_q;
    rsp_o.reader_count  = readers_q;
    rsp_o.writer_holds  = writer_q;

    unique case (state_q)
      frwl_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          status_d = frwl_pkg::STATUS_OK;
          state_d  = frwl_pkg::ST_SERVE;
          unique case (req_i.action)
            frwl_pkg::ACT_READ_REQ, frwl_pkg::ACT_WRITE_REQ: begin
              if (fill_q == CNT_W'(QUEUE_DEPTH)) begin
                status_d = frwl_pkg::STATUS_FULL;
                state_d  = frwl_pkg::ST_REPORT;
              end else begin
                wr_en  = 1'b1;
                fill_d = fill_q + CNT_W'(1);
              end
            end
            frwl_pkg::ACT_READ_REL: begin
              if (readers_q == '0) begin
                status_d = frwl_pkg::STATUS_NO_HOLDER;
                state_d  = frwl_pkg::ST_REPORT;
              end else begin
                readers_d = readers_q - RC_W'(1);
              end
            end
            frwl_pkg::ACT_WRITE_REL: begin
              if (!writer_q) begin
                status_d = frwl_pkg::STATUS_NO_HOLDER;
                state_d  = frwl_pkg::ST_REPORT;
              end else begin
                writer_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      frwl_pkg::ST_SERVE: begin
        ngrant_d    = '0;
        emit_slot_d = head_q;
        if (fill_q == '0) begin
          state_d = frwl_pkg::ST_REPORT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_q;
          state_d = frwl_pkg::ST_SCAN;
        end
      end

      frwl_pkg::ST_SCAN: begin
        // The head entry was read last cycle; grant it or close the batch.
        if (entry_write) begin
          take = (ngrant_q == '0) && (readers_q == '0) && !writer_q;
        end else begin
          take = !writer_q && (readers_q != RC_W'(READER_MAX));
        end
        if (take) begin
          ngrant_after = ngrant_q + CNT_W'(1);
          head_d       = slot_next(head_q);
          fill_d       = fill_q - CNT_W'(1);
          if (entry_write) begin
            writer_d = 1'b1;
          end else begin
            readers_d = readers_q + RC_W'(1);
          end
        end
        ngrant_d = ngrant_after;
        if (take && !entry_write && (fill_q > CNT_W'(1))) begin
          rd_en   = 1'b1;
          rd_addr = slot_next(head_q);
        end else if (ngrant_after == '0) begin
          state_d = frwl_pkg::ST_REPORT;
        end else begin
          // Read the first granted entry back for reporting.
          rd_en      = 1'b1;
          rd_addr    = emit_slot_q;
          emit_idx_d = '0;
          state_d    = frwl_pkg::ST_EMIT;
        end
      end

      frwl_pkg::ST_EMIT: begin
        rsp_o.valid       = 1'b1;
        rsp_o.grant_valid = 1'b1;
        rsp_o.grant_id    = rdata_q[ID_BITS-1:0];
        rsp_o.grant_write = entry_write;
        rsp_o.last        = emit_last;
        if (rsp_o.ready) begin
          if (emit_last) begin
            state_d = frwl_pkg::ST_IDLE;
          end else begin
            emit_idx_d  = emit_idx_q + CNT_W'(1);
            emit_slot_d = slot_next(emit_slot_q);
            rd_en       = 1'b1;
            rd_addr     = slot_next(emit_slot_q);
          end
        end
      end

      frwl_pkg::ST_REPORT: begin
        rsp_o.valid = 1'b1;
        if (rsp_o.ready) begin
          state_d = frwl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = frwl_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(QUEUE_DEPTH))
    else $error("wait queue fill count exceeds its depth");

  a_excl_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(writer_q && (readers_q != '0)))
    else $error("writer and readers hold the lock together");

  a_reader_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    readers_q <= RC_W'(READER_MAX))
    else $error("reader count above its ceiling");

  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.ready && rsp_o.last) |=> req_i.ready)
    else $error("event port not ready after the final result transaction");

  a_grant_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.grant_valid) |-> (rsp_o.status == frwl_pkg::STATUS_OK))
    else $error("grant transaction carries an error status");
`endif

endmodule

// File: dv/fair_readers_writer_lock_arbiter_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the fair reader/writer lock arbiter.
// A lock tracker class predicts the grants of each event and checks every result transaction.
// Depends on frwl_pkg, frwl_req_if, frwl_rsp_if and fair_readers_writer_lock_arbiter.
module fair_readers_writer_lock_arbiter_test;
  import frwl_pkg::*;

  localparam int unsigned DEPTH       = QUEUE_DEPTH_DEF;
  localparam int unsigned IDW         = ID_BITS_DEF;
  localparam int unsigned READER_MAX  = 1 << IDW;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_EVENTS = 48;

  typedef logic [IDW:0] field_t;

  typedef struct {
    logic           grant_valid;
    logic [IDW-1:0] grant_id;
    logic           grant_write;
    logic           last;
    status_e        status;
    logic [4:0]     pending_count;
    logic [IDW:0]   reader_count;
    logic           writer_holds;
  } grant_t;

  // Tracks the lock and its wait queue, and holds the results still owed by the block.
  class lock_tracker;
    logic [IDW:0]   slots [DEPTH];   // top bit marks a write request
    logic [IDW:0]   batch [$];
    int unsigned    head, fill, readers;
    bit             writer;
    grant_t         due [$];
    int unsigned    errors, read_grants, write_grants, full_refusals, orphan_releases;
    int unsigned    widest_batch, peak_readers, peak_fill;
    int unsigned    events_by_action [4];

    function new();
      head = 0; fill = 0; readers = 0; writer = 0;
    endfunction

    function void pop_head();
      batch.push_back(slots[head]);
      head = (head + 1) % DEPTH;
      fill--;
    endfunction

    // Serves the head of the queue: a run of reads, or a single write.
    function void serve();
      batch.delete();
      if (fill == 0) return;
      if (!slots[head][IDW]) begin
        if (writer) return;
        while (fill > 0 && batch.size() < DEPTH && !slots[head][IDW] &&
               readers < READER_MAX) begin
          readers++;
          pop_head();
        end
      end else if (readers == 0 && !writer) begin
        writer = 1;
        pop_head();
      end
    endfunction

    function void note_event(action_e act, logic [IDW-1:0] id);
      status_e st;
      grant_t  r;
      st = STATUS_OK;
      batch.delete();
      events_by_action[act]++;
      case (act)
        ACT_READ_REQ, ACT_WRITE_REQ: begin
          if (fill >= DEPTH) begin
            st = STATUS_FULL;
          end else begin
            slots[(head + fill) % DEPTH] = {act == ACT_WRITE_REQ, id};
            fill++;
            serve();
          end
        end
        ACT_READ_REL: begin
          if (readers == 0) begin
            st = STATUS_NO_HOLDER;
          end else begin
            readers--;
            serve();
          end
        end
        ACT_WRITE_REL: begin
          if (!writer) begin
            st = STATUS_NO_HOLDER;
          end else begin
            writer = 0;
            serve();
          end
        end
      endcase
      if (st == STATUS_FULL) full_refusals++;
      if (st == STATUS_NO_HOLDER) orphan_releases++;
      if (batch.size() > widest_batch) widest_batch = batch.size();
      if (readers > peak_readers) peak_readers = readers;
      if (fill > peak_fill) peak_fill = fill;
      r.status        = st;
      r.pending_count = fill[4:0];
      r.reader_count  = readers[IDW:0];
      r.writer_holds  = writer;
      if (batch.size() == 0) begin
        r.grant_valid = 1'b0;
        r.grant_id    = '0;
        r.grant_write = 1'b0;
        r.last        = 1'b1;
        due.push_back(r);
      end else begin
        foreach (batch[k]) begin
          r.grant_valid = 1'b1;
          r.grant_id    = batch[k][IDW-1:0];
          r.grant_write = batch[k][IDW];
          r.last        = (k == batch.size() - 1);
          if (batch[k][IDW]) write_grants++;
          else read_grants++;
          due.push_back(r);
        end
      end
    endfunction

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, field_t got, field_t want);
      if (got !== want) report($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task check_grant(grant_t got);
      grant_t want;
      if (due.size() == 0) begin
        report("result transaction with no event outstanding");
        return;
      end
      want = due.pop_front();
      compare_field("grant_valid", field_t'(got.grant_valid), field_t'(want.grant_valid));
      compare_field("grant_id", field_t'(got.grant_id), field_t'(want.grant_id));
      compare_field("grant_write", field_t'(got.grant_write), field_t'(want.grant_write));
      compare_field("last", field_t'(got.last), field_t'(want.last));
      compare_field("status", field_t'(got.status), field_t'(want.status));
      compare_field("pending_count", field_t'(got.pending_count),
                    field_t'(want.pending_count));
      compare_field("reader_count", got.reader_count, want.reader_count);
      compare_field("writer_holds", field_t'(got.writer_holds),
                    field_t'(want.writer_holds));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          steady;
  int unsigned cycles;
  lock_tracker book;

  frwl_req_if #(.ID_BITS(IDW)) req_if ();
  frwl_rsp_if #(.QUEUE_DEPTH(DEPTH), .ID_BITS(IDW)) rsp_if ();

  fair_readers_writer_lock_arbiter #(
    .QUEUE_DEPTH(DEPTH),
    .ID_BITS    (IDW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    rsp_if.ready <= steady || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk_i) begin : watch_results
    grant_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.grant_valid   = rsp_if.grant_valid;
      got.grant_id      = rsp_if.grant_id;
      got.grant_write   = rsp_if.grant_write;
      got.last          = rsp_if.last;
      got.status        = rsp_if.status;
      got.pending_count = rsp_if.pending_count;
      got.reader_count  = rsp_if.reader_count;
      got.writer_holds  = rsp_if.writer_holds;
      book.check_grant(got);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Presents one event and returns at the falling edge after its transaction.
  task send(action_e act, logic [IDW-1:0] id);
    while (!steady && $urandom_range(0, 99) < 8) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.requester_id <= id;
    do @(posedge clk_i); while (!req_if.ready);
    book.note_event(act, id);
    @(negedge clk_i);
  endtask

  task hold_until_quiet();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (book.due.size() != 0);
  endtask

  // Mostly legal traffic: requests while filling, releases of held locks while draining,
  // and a little noise that may release nothing or hit a full queue.
  function automatic action_e pick_action(bit filling);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return action_e'($urandom_range(0, 3));
    if (filling ? r < 75 : r < 25)
      return ($urandom_range(0, 2) == 0) ? ACT_WRITE_REQ : ACT_READ_REQ;
    if (book.writer && (book.readers == 0 || $urandom_range(0, 1) == 1)) return ACT_WRITE_REL;
    if (book.readers > 0) return ACT_READ_REL;
    return ACT_READ_REQ;
  endfunction

  initial begin
    int unsigned i;
    int unsigned run_left;
    bit          filling;
    rst_ni              = 1'b0;
    steady              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.action       = ACT_READ_REQ;
    req_if.requester_id = '0;
    book                = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Releases with nobody holding, then a write held up by a reader and a read behind it.
    send(ACT_READ_REL,  8'h00);
    send(ACT_WRITE_REL, 8'hFF);
    send(ACT_READ_REQ,  8'h00);
    send(ACT_WRITE_REQ, 8'hFF);
    send(ACT_READ_REQ,  8'h55);
    send(ACT_READ_REL,  8'h00);
    send(ACT_WRITE_REL, 8'hFF);
    send(ACT_READ_REL,  8'hAA);
    // A writer holds while reads fill the queue; the last one is refused, and the
    // write release then grants the whole queue in one batch.
    send(ACT_WRITE_REQ, 8'hAA);
    for (i = 0; i < DEPTH + 1; i++) send(ACT_READ_REQ, 8'(i * 15 + 1));
    send(ACT_WRITE_REL, 8'hAA);
    hold_until_quiet();

    filling  = 1'b1;
    run_left = $urandom_range(8, 20);
    for (i = 0; i < RANDOM_EVENTS; i++) begin
      if (run_left == 0) begin
        filling  = !filling;
        run_left = $urandom_range(8, 20);
      end
      run_left--;
      steady = (i >= 16 && i < 32);
      send(pick_action(filling), 8'($urandom_range(0, 255)));
      if (i % 24 == 23) hold_until_quiet();
    end
    steady = 1'b0;

    // Release every holder, then take the reader count up to its ceiling with no idling.
    while (book.writer || book.readers > 0 || book.fill > 0) begin
      if (book.writer) send(ACT_WRITE_REL, 8'($urandom_range(0, 255)));
      else send(ACT_READ_REL, 8'($urandom_range(0, 255)));
    end
    steady = 1'b1;
    for (i = 0; i < READER_MAX + DEPTH + 2; i++) send(ACT_READ_REQ, 8'($urandom_range(0, 255)));
    steady = 1'b0;
    send(ACT_READ_REL,  8'($urandom_range(0, 255)));
    send(ACT_WRITE_REL, 8'($urandom_range(0, 255)));
    send(ACT_READ_REL,  8'($urandom_range(0, 255)));

    hold_until_quiet();
    repeat (40) @(posedge clk_i);

    $display("Covered %0d read requests, %0d write requests, %0d read and %0d write releases.",
             book.events_by_action[ACT_READ_REQ], book.events_by_action[ACT_WRITE_REQ],
             book.events_by_action[ACT_READ_REL], book.events_by_action[ACT_WRITE_REL]);
    $display("Grants %0d read / %0d write, widest batch %0d, %0d full, %0d orphan releases,",
             book.read_grants, book.write_grants, book.widest_batch, book.full_refusals,
             book.orphan_releases);
    $display("peak of %0d readers and %0d queued requests.", book.peak_readers, book.peak_fill);
    if (book.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
